[hw/rtl/cpu8080_alu_flags_unit_core_assert.svh]
// assertion macros shared by the alu80 rtl
`ifndef CPU8080_ALU_FLAGS_UNIT_CORE_ASSERT_SVH
`define CPU8080_ALU_FLAGS_UNIT_CORE_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define ALU80_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ALU80_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

// condition that must hold in the same cycle as a trigger
`define ALU80_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

`endif

[hw/rtl/alu80_pkg.sv]
`timescale 1ns / 1ps

package alu80_pkg;

    // command codes of the request beat
    localparam logic [4:0] CMD_ADD = 5'd0;
    localparam logic [4:0] CMD_ADC = 5'd1;
    localparam logic [4:0] CMD_SUB = 5'd2;
    localparam logic [4:0] CMD_SBB = 5'd3;
    localparam logic [4:0] CMD_ANA = 5'd4;
    localparam logic [4:0] CMD_XRA = 5'd5;
    localparam logic [4:0] CMD_ORA = 5'd6;
    localparam logic [4:0] CMD_CMP = 5'd7;
    localparam logic [4:0] CMD_INR = 5'd8;
    localparam logic [4:0] CMD_DCR = 5'd9;
    localparam logic [4:0] CMD_RLC = 5'd10;
    localparam logic [4:0] CMD_RRC = 5'd11;
    localparam logic [4:0] CMD_RAL = 5'd12;
    localparam logic [4:0] CMD_RAR = 5'd13;
    localparam logic [4:0] CMD_CMA = 5'd14;
    localparam logic [4:0] CMD_CMC = 5'd15;
    localparam logic [4:0] CMD_STC = 5'd16;
    localparam logic [4:0] CMD_DAA = 5'd17;
    localparam logic [4:0] CMD_DAD = 5'd18;
    localparam logic [4:0] CMD_LDA = 5'd19;
    localparam logic [4:0] CMD_LDF = 5'd20;

    // flag byte layout: S Z 0 A 0 P 1 C
    localparam int FLAG_CY_BIT = 0;
    localparam int FLAG_P_BIT  = 2;
    localparam int FLAG_AC_BIT = 4;
    localparam int FLAG_Z_BIT  = 6;
    localparam int FLAG_S_BIT  = 7;

    localparam logic [7:0] FLAGS_FIXED_ONES = 8'h02;
    localparam logic [7:0] FLAGS_FIXED_MASK = 8'hD7;

    // decimal adjust corrections
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

    // decoupling queue between decode and execute
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [4:0] {
        OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_ANA, OP_XRA, OP_ORA, OP_CMP,
        OP_INR, OP_DCR, OP_RLC, OP_RRC, OP_RAL, OP_RAR, OP_CMA, OP_CMC,
        OP_STC, OP_DAA, OP_DAD, OP_LDA, OP_LDF, OP_NOP
    } op_t;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [7:0]  operand;
        logic [15:0] pair_value;
        logic [15:0] hl_value;
    } req_t;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  flags_out;
        logic [7:0]  reg_result;
        logic [15:0] pair_result;
    } rsp_t;

    // decoded operation waiting in the queue
    typedef struct packed {
        op_t         op;
        logic [7:0]  operand;
        logic [15:0] pair_value;
        logic [15:0] hl_value;
    } dec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[hw/rtl/alu80_front.sv]
`timescale 1ns / 1ps

module alu80_front
(
    input  logic                  req_valid,
    output logic                  req_stall,
    input  alu80_pkg::req_t       req,
    input  alu80_pkg::qstat_t     qstat,
    output logic                  push,
    output alu80_pkg::dec_t       entry
);

    // decode command code into an operation class
    always_comb
    begin
        case (req.cmd)
            alu80_pkg::CMD_ADD: entry.op = alu80_pkg::OP_ADD;
            alu80_pkg::CMD_ADC: entry.op = alu80_pkg::OP_ADC;
            alu80_pkg::CMD_SUB: entry.op = alu80_pkg::OP_SUB;
            alu80_pkg::CMD_SBB: entry.op = alu80_pkg::OP_SBB;
            alu80_pkg::CMD_ANA: entry.op = alu80_pkg::OP_ANA;
            alu80_pkg::CMD_XRA: entry.op = alu80_pkg::OP_XRA;
            alu80_pkg::CMD_ORA: entry.op = alu80_pkg::OP_ORA;
            alu80_pkg::CMD_CMP: entry.op = alu80_pkg::OP_CMP;
            alu80_pkg::CMD_INR: entry.op = alu80_pkg::OP_INR;
            alu80_pkg::CMD_DCR: entry.op = alu80_pkg::OP_DCR;
            alu80_pkg::CMD_RLC: entry.op = alu80_pkg::OP_RLC;
            alu80_pkg::CMD_RRC: entry.op = alu80_pkg::OP_RRC;
            alu80_pkg::CMD_RAL: entry.op = alu80_pkg::OP_RAL;
            alu80_pkg::CMD_RAR: entry.op = alu80_pkg::OP_RAR;
            alu80_pkg::CMD_CMA: entry.op = alu80_pkg::OP_CMA;
            alu80_pkg::CMD_CMC: entry.op = alu80_pkg::OP_CMC;
            alu80_pkg::CMD_STC: entry.op = alu80_pkg::OP_STC;
            alu80_pkg::CMD_DAA: entry.op = alu80_pkg::OP_DAA;
            alu80_pkg::CMD_DAD: entry.op = alu80_pkg::OP_DAD;
            alu80_pkg::CMD_LDA: entry.op = alu80_pkg::OP_LDA;
            alu80_pkg::CMD_LDF: entry.op = alu80_pkg::OP_LDF;
            default:            entry.op = alu80_pkg::OP_NOP;
        endcase
        entry.operand    = req.operand;
        entry.pair_value = req.pair_value;
        entry.hl_value   = req.hl_value;
    end

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;

endmodule

[hw/rtl/alu80_queue.sv]
`timescale 1ns / 1ps

module alu80_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  alu80_pkg::dec_t     push_data,
    input  logic                pop,
    output alu80_pkg::dec_t     head,
    output alu80_pkg::qstat_t   qstat
);

    localparam logic [alu80_pkg::Q_PTR_W-1:0] PTR_LAST =
        alu80_pkg::Q_PTR_W'(alu80_pkg::Q_DEPTH - 1);
    localparam logic [alu80_pkg::Q_PTR_W:0] CNT_FULL =
        (alu80_pkg::Q_PTR_W + 1)'(alu80_pkg::Q_DEPTH);

    alu80_pkg::dec_t                 slot_reg [alu80_pkg::Q_DEPTH];
    logic [alu80_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [alu80_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [alu80_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [alu80_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [alu80_pkg::Q_PTR_W:0]     count_reg;
    logic [alu80_pkg::Q_PTR_W:0]     count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);

endmodule

[hw/rtl/alu80_back.sv]
`timescale 1ns / 1ps
`include "cpu8080_alu_flags_unit_core_assert.svh"

module alu80_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  alu80_pkg::dec_t     head,
    input  alu80_pkg::qstat_t   qstat,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output alu80_pkg::rsp_t     rsp
);

    logic [7:0]       acc_reg;
    logic [7:0]       acc_next;
    logic [7:0]       flags_reg;
    logic [7:0]       flags_next;
    logic             rsp_valid_reg;
    alu80_pkg::rsp_t  rsp_reg;
    alu80_pkg::rsp_t  rsp_next;

    // adder datapath
    logic             is_sub;
    logic             cin_raw;
    logic             cin;
    logic [7:0]       b_eff;
    logic [8:0]       sum9;
    logic [4:0]       nib_sum;

    // decimal adjust
    logic             daa_lo;
    logic             daa_hi;
    logic [7:0]       daa_corr;
    logic [7:0]       daa_res;
    logic [4:0]       daa_nib;

    logic [16:0]      dad_sum;
    logic [7:0]       inr_res;
    logic [7:0]       dcr_res;
    logic             cy;
    logic [7:0]       szp_src;
    logic             szp_upd;
    logic [7:0]       reg_res;
    logic [15:0]      pair_res;

    assign cy = flags_reg[alu80_pkg::FLAG_CY_BIT];

    always_comb
    begin
        is_sub  = (head.op == alu80_pkg::OP_SUB) || (head.op == alu80_pkg::OP_SBB)
               || (head.op == alu80_pkg::OP_CMP);
        cin_raw = ((head.op == alu80_pkg::OP_ADC) || (head.op == alu80_pkg::OP_SBB)) && cy;
        cin     = is_sub ? !cin_raw : cin_raw;
        b_eff   = is_sub ? ~head.operand : head.operand;
        sum9    = {1'b0, acc_reg} + {1'b0, b_eff} + {8'b0, cin};
        nib_sum = {1'b0, acc_reg[3:0]} + {1'b0, b_eff[3:0]} + {4'b0, cin};

        daa_lo   = flags_reg[alu80_pkg::FLAG_AC_BIT]
                || (acc_reg[3:0] > alu80_pkg::BCD_DIGIT_MAX);
        daa_hi   = cy || (acc_reg[7:4] > alu80_pkg::BCD_DIGIT_MAX)
                || ((acc_reg[7:4] >= alu80_pkg::BCD_DIGIT_MAX)
                    && (acc_reg[3:0] > alu80_pkg::BCD_DIGIT_MAX));
        daa_corr = (daa_lo ? alu80_pkg::DAA_LO_ADJ : 8'h00)
                 | (daa_hi ? alu80_pkg::DAA_HI_ADJ : 8'h00);
        daa_res  = acc_reg + daa_corr;
        daa_nib  = {1'b0, acc_reg[3:0]} + {1'b0, daa_corr[3:0]};

        dad_sum = {1'b0, head.hl_value} + {1'b0, head.pair_value};
        inr_res = head.operand + 8'd1;
        dcr_res = head.operand - 8'd1;
    end

    // per-operation results
    always_comb
    begin
        acc_next   = acc_reg;
        flags_next = flags_reg;
        szp_src    = 8'h00;
        szp_upd    = 1'b0;
        reg_res    = 8'h00;
        pair_res   = 16'h0000;
        case (head.op)
            alu80_pkg::OP_ADD, alu80_pkg::OP_ADC,
            alu80_pkg::OP_SUB, alu80_pkg::OP_SBB:
            begin
                acc_next = sum9[7:0];
                szp_src  = sum9[7:0];
                szp_upd  = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = nib_sum[4];
                flags_next[alu80_pkg::FLAG_CY_BIT] = is_sub ? !sum9[8] : sum9[8];
            end
            alu80_pkg::OP_CMP:
            begin
                szp_src  = sum9[7:0];
                szp_upd  = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = nib_sum[4];
                flags_next[alu80_pkg::FLAG_CY_BIT] = !sum9[8];
            end
            alu80_pkg::OP_ANA:
            begin
                acc_next = acc_reg & head.operand;
                szp_src  = acc_reg & head.operand;
                szp_upd  = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = acc_reg[3] | head.operand[3];
                flags_next[alu80_pkg::FLAG_CY_BIT] = 1'b0;
            end
            alu80_pkg::OP_XRA, alu80_pkg::OP_ORA:
            begin
                acc_next = (head.op == alu80_pkg::OP_XRA) ? (acc_reg ^ head.operand)
                                                          : (acc_reg | head.operand);
                szp_src  = acc_next;
                szp_upd  = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = 1'b0;
                flags_next[alu80_pkg::FLAG_CY_BIT] = 1'b0;
            end
            alu80_pkg::OP_INR:
            begin
                reg_res = inr_res;
                szp_src = inr_res;
                szp_upd = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = (inr_res[3:0] == 4'h0);
            end
            alu80_pkg::OP_DCR:
            begin
                reg_res = dcr_res;
                szp_src = dcr_res;
                szp_upd = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = (dcr_res[3:0] != 4'hF);
            end
            alu80_pkg::OP_RLC:
            begin
                acc_next = {acc_reg[6:0], acc_reg[7]};
                flags_next[alu80_pkg::FLAG_CY_BIT] = acc_reg[7];
            end
            alu80_pkg::OP_RRC:
            begin
                acc_next = {acc_reg[0], acc_reg[7:1]};
                flags_next[alu80_pkg::FLAG_CY_BIT] = acc_reg[0];
            end
            alu80_pkg::OP_RAL:
            begin
                acc_next = {acc_reg[6:0], cy};
                flags_next[alu80_pkg::FLAG_CY_BIT] = acc_reg[7];
            end
            alu80_pkg::OP_RAR:
            begin
                acc_next = {cy, acc_reg[7:1]};
                flags_next[alu80_pkg::FLAG_CY_BIT] = acc_reg[0];
            end
            alu80_pkg::OP_CMA:
            begin
                acc_next = ~acc_reg;
            end
            alu80_pkg::OP_CMC:
            begin
                flags_next[alu80_pkg::FLAG_CY_BIT] = !cy;
            end
            alu80_pkg::OP_STC:
            begin
                flags_next[alu80_pkg::FLAG_CY_BIT] = 1'b1;
            end
            alu80_pkg::OP_DAA:
            begin
                acc_next = daa_res;
                szp_src  = daa_res;
                szp_upd  = 1'b1;
                flags_next[alu80_pkg::FLAG_AC_BIT] = daa_nib[4];
                flags_next[alu80_pkg::FLAG_CY_BIT] = daa_hi ? 1'b1 : cy;
            end
            alu80_pkg::OP_DAD:
            begin
                pair_res = dad_sum[15:0];
                flags_next[alu80_pkg::FLAG_CY_BIT] = dad_sum[16];
            end
            alu80_pkg::OP_LDA:
            begin
                acc_next = head.operand;
            end
            alu80_pkg::OP_LDF:
            begin
                flags_next = (head.operand & alu80_pkg::FLAGS_FIXED_MASK)
                           | alu80_pkg::FLAGS_FIXED_ONES;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
        if (szp_upd)
        begin
            flags_next[alu80_pkg::FLAG_S_BIT] = szp_src[7];
            flags_next[alu80_pkg::FLAG_Z_BIT] = (szp_src == 8'h00);
            flags_next[alu80_pkg::FLAG_P_BIT] = ~^szp_src;
        end
        rsp_next.acc_out     = acc_next;
        rsp_next.flags_out   = flags_next;
        rsp_next.reg_result  = reg_res;
        rsp_next.pair_result = pair_res;
    end

    // execute when the output register is free or being drained
    assign pop = !qstat.empty && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'h00;
            flags_reg     <= alu80_pkg::FLAGS_FIXED_ONES;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg       <= acc_next;
                flags_reg     <= flags_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ALU80_ASSERT_ALWAYS(a_fixed_flag_bits,
        (flags_reg & (~alu80_pkg::FLAGS_FIXED_MASK | alu80_pkg::FLAGS_FIXED_ONES))
            == alu80_pkg::FLAGS_FIXED_ONES,
        "fixed flag bits corrupted")
    `ALU80_ASSERT_NEXT(a_pop_fills_output, pop, rsp_valid_reg,
        "executed beat did not reach the output register")
    `ALU80_ASSERT_NEXT(a_cmp_keeps_acc, pop && (head.op == alu80_pkg::OP_CMP),
        acc_reg == $past(acc_reg), "compare changed the accumulator")
    `ALU80_ASSERT_SAME(a_rsp_tracks_state, rsp_valid_reg,
        (rsp_reg.acc_out == acc_reg) && (rsp_reg.flags_out == flags_reg),
        "pending result disagrees with architectural state")

endmodule

[hw/rtl/cpu8080_alu_flags_unit_core.sv]
`timescale 1ns / 1ps

// 8080-style accumulator and flag unit. Each request beat carries a command,
// an 8-bit operand and two 16-bit pair values; each accepted beat yields
// exactly one response beat with the new accumulator, the new flag byte
// (S Z 0 A 0 P 1 C), the inr/dcr register result and the dad sum. A decode
// front end classifies the command and writes a two-entry queue; the execute
// back end owns the accumulator and flags, runs one operation per cycle and
// holds the result in an output register. Throughput is one beat per clock
// while the response side takes every beat. An accepted request beat is
// written into the queue, then executes from the queue head into the output
// register, and its response beat is valid from then on; execution is held
// back only while the response side stalls. Reset leaves the accumulator at
// zero and the flags at 0x02.
module cpu8080_alu_flags_unit_core
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  alu80_pkg::req_t     req,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output alu80_pkg::rsp_t     rsp
);

    // decoded beat entering the queue
    alu80_pkg::dec_t    q_in;
    // oldest decoded beat, presented to execute
    alu80_pkg::dec_t    q_head;
    alu80_pkg::qstat_t  q_stat;
    logic               q_push;
    logic               q_pop;

    // decode: classify command, stall only when the queue is full
    alu80_front u_front
    (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .qstat     (q_stat),
        .push      (q_push),
        .entry     (q_in)
    );

    // decoupling queue lets decode and execute stall independently
    alu80_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (q_stat)
    );

    // execute: accumulator, flags and the response register
    alu80_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .qstat     (q_stat),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
